/* sv/nacm_pkg.sv */
// ----------------------------------------------------------------------------
// nacm_pkg: shared definitions for the normalize and colormap pixel pipeline
// Fixed-point widths, register map codes, stage payload types and the
// five-stop colormap table.
// ----------------------------------------------------------------------------
package nacm_pkg;

    // Fractional bits of the sample, the bounds and the normalized value.
    localparam int FRAC_BITS = 16;

    localparam int SAMPLE_W   = 24;              // sample and bound width
    localparam int DIFF_W     = SAMPLE_W + 1;    // sample - lower_bound
    localparam int RNG_W      = SAMPLE_W + 1;    // range and divider remainder
    localparam int V_W        = FRAC_BITS + 1;   // normalized value, Q1.FRAC_BITS
    localparam int CHAN_W     = 8;               // one color channel
    localparam int DELTA_W    = CHAN_W + 1;      // signed stop difference
    localparam int PROD_W     = DELTA_W + V_W + 1;
    localparam int ACC_W      = PROD_W;
    localparam int DIV_STAGES = FRAC_BITS;       // one quotient bit per stage
    localparam int GRAY_W     = V_W + CHAN_W;

    localparam logic [V_W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [V_W-1:0] HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

    // Register map.
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_LOWER = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_UPPER = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_GRAY  = 2'd2;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } t_rgb;

    typedef struct packed {
        logic signed [DELTA_W-1:0] r;
        logic signed [DELTA_W-1:0] g;
        logic signed [DELTA_W-1:0] b;
    } t_delta;

    // Operands handed from the normalizer front end to the divider.
    typedef struct packed {
        logic [RNG_W-1:0] rem;
        logic [RNG_W-1:0] rng;
        logic             zero;   // sample at or below the lower bound
        logic             sat;    // sample at or beyond the full range
    } t_div_op;

    // Divider result: quotient plus the clamp flags.
    typedef struct packed {
        logic [FRAC_BITS-1:0] quo;
        logic                 zero;
        logic                 sat;
    } t_div_res;

    // Colormap stops, darkest first.
    function automatic t_rgb stop_rgb(input logic [2:0] idx);
        t_rgb c;
        unique case (idx)
            3'd0:    c = '{r: 8'd68,  g: 8'd1,   b: 8'd84};
            3'd1:    c = '{r: 8'd59,  g: 8'd82,  b: 8'd139};
            3'd2:    c = '{r: 8'd33,  g: 8'd145, b: 8'd140};
            3'd3:    c = '{r: 8'd94,  g: 8'd201, b: 8'd98};
            3'd4:    c = '{r: 8'd253, g: 8'd231, b: 8'd37};
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

/* sv/nacm_norm.sv */
// ----------------------------------------------------------------------------
// nacm_norm: normalizer front end
// Two stages: offset and range, then the clamp flags for the divider.
// ----------------------------------------------------------------------------
module nacm_norm (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [nacm_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic [nacm_pkg::SAMPLE_W-1:0]    i_lower,
    input  logic [nacm_pkg::SAMPLE_W-1:0]    i_upper,
    output logic                             o_valid,
    output nacm_pkg::t_div_op                o_op
);

    logic                            r_vld1;
    logic [nacm_pkg::DIFF_W-1:0]     r_diff;
    logic [nacm_pkg::RNG_W-1:0]      r_rng;
    logic [nacm_pkg::DIFF_W-1:0]     n_diff;
    logic [nacm_pkg::RNG_W-1:0]      n_rng;
    logic                            r_vld2;
    nacm_pkg::t_div_op               r_op;
    nacm_pkg::t_div_op               n_op;

    // Stage 1: signed offset and the effective range.
    always_comb begin
        n_diff = {i_sample[nacm_pkg::SAMPLE_W-1], i_sample}
               - {i_lower[nacm_pkg::SAMPLE_W-1], i_lower};
        if ($signed(i_upper) > $signed(i_lower)) begin
            n_rng = {i_upper[nacm_pkg::SAMPLE_W-1], i_upper}
                  - {i_lower[nacm_pkg::SAMPLE_W-1], i_lower};
        end else begin
            n_rng = nacm_pkg::RNG_W'(nacm_pkg::ONE);
        end
    end

    // Stage 2: clamp flags. The remainder is meaningless when a flag is set.
    always_comb begin
        n_op.zero = r_diff[nacm_pkg::DIFF_W-1] || (r_diff == '0);
        n_op.sat  = !n_op.zero && (r_diff >= r_rng);
        n_op.rem  = r_diff;
        n_op.rng  = r_rng;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= n_diff;
            r_rng  <= n_rng;
            r_op   <= n_op;
        end
    end

    assign o_valid = r_vld2;
    assign o_op    = r_op;

endmodule

/* sv/nacm_div.sv */
// ----------------------------------------------------------------------------
// nacm_div: pipelined restoring divider
// Produces floor(rem * 2^FRAC_BITS / rng) for rem < rng, one quotient bit
// per register stage.
// ----------------------------------------------------------------------------
module nacm_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  nacm_pkg::t_div_op    i_op,
    output logic                 o_valid,
    output nacm_pkg::t_div_res   o_res
);

    localparam int N = nacm_pkg::DIV_STAGES;

    logic                             r_vld  [N];
    logic [nacm_pkg::RNG_W-1:0]       r_rem  [N];
    logic [nacm_pkg::RNG_W-1:0]       r_rng  [N];
    logic [nacm_pkg::FRAC_BITS-1:0]   r_quo  [N];
    logic                             r_zero [N];
    logic                             r_sat  [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic                             w_vld_in;
        logic [nacm_pkg::RNG_W-1:0]       w_rem_in;
        logic [nacm_pkg::RNG_W-1:0]       w_rng_in;
        logic [nacm_pkg::FRAC_BITS-1:0]   w_quo_in;
        logic                             w_zero_in;
        logic                             w_sat_in;
        logic [nacm_pkg::RNG_W:0]         w_shift;
        logic                             w_bit;
        logic [nacm_pkg::RNG_W-1:0]       n_rem;
        logic [nacm_pkg::FRAC_BITS-1:0]   n_quo;

        if (k == 0) begin : g_first
            assign w_vld_in  = i_valid;
            assign w_rem_in  = i_op.rem;
            assign w_rng_in  = i_op.rng;
            assign w_quo_in  = '0;
            assign w_zero_in = i_op.zero;
            assign w_sat_in  = i_op.sat;
        end else begin : g_next
            assign w_vld_in  = r_vld[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_rng_in  = r_rng[k-1];
            assign w_quo_in  = r_quo[k-1];
            assign w_zero_in = r_zero[k-1];
            assign w_sat_in  = r_sat[k-1];
        end

        always_comb begin
            w_shift = {w_rem_in, 1'b0};
            w_bit   = (w_shift >= {1'b0, w_rng_in});
            if (w_bit) begin
                n_rem = nacm_pkg::RNG_W'(w_shift - {1'b0, w_rng_in});
            end else begin
                n_rem = w_shift[nacm_pkg::RNG_W-1:0];
            end
            n_quo = {w_quo_in[nacm_pkg::FRAC_BITS-2:0], w_bit};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_rng[k]  <= w_rng_in;
                r_quo[k]  <= n_quo;
                r_zero[k] <= w_zero_in;
                r_sat[k]  <= w_sat_in;
            end
        end
    end

    assign o_valid    = r_vld[N-1];
    assign o_res.quo  = r_quo[N-1];
    assign o_res.zero = r_zero[N-1];
    assign o_res.sat  = r_sat[N-1];

endmodule

/* sv/nacm_cmap.sv */
// ----------------------------------------------------------------------------
// nacm_cmap: colormap stages
// Segment select and stop lookup, then the interpolation multiply; the final
// rounding add is left combinational for the output register.
// ----------------------------------------------------------------------------
module nacm_cmap (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  nacm_pkg::t_div_res   i_res,
    input  logic                 i_gray,
    output logic                 o_valid,
    output nacm_pkg::t_rgb       o_rgb
);

    // Rounds a*2^F + prod + 2^(F-1) down to one channel byte.
    function automatic logic [nacm_pkg::CHAN_W-1:0] lerp_finish(
        input logic [nacm_pkg::CHAN_W-1:0] a,
        input logic [nacm_pkg::PROD_W-1:0] prod
    );
        logic [nacm_pkg::ACC_W-1:0] acc;
        acc = {{(nacm_pkg::ACC_W-nacm_pkg::CHAN_W-nacm_pkg::FRAC_BITS){1'b0}},
               a, {nacm_pkg::FRAC_BITS{1'b0}}}
            + prod
            + {{(nacm_pkg::ACC_W-nacm_pkg::V_W){1'b0}}, nacm_pkg::HALF};
        if (acc[nacm_pkg::ACC_W-1]) begin
            return '0;
        end
        return acc[nacm_pkg::FRAC_BITS+nacm_pkg::CHAN_W-1:nacm_pkg::FRAC_BITS];
    endfunction

    logic [nacm_pkg::V_W-1:0]      w_v;
    logic [nacm_pkg::GRAY_W-1:0]   w_gray_acc;
    logic [2:0]                    w_seg_raw;
    logic [1:0]                    w_seg;
    logic [nacm_pkg::V_W+1:0]      w_t_wide;
    nacm_pkg::t_rgb                w_a;
    nacm_pkg::t_rgb                w_b;
    nacm_pkg::t_delta              n_delta;

    logic                          r_vld_a;
    nacm_pkg::t_rgb                r_a_a;
    nacm_pkg::t_delta              r_delta;
    logic [nacm_pkg::V_W-1:0]      r_t;
    logic [nacm_pkg::CHAN_W-1:0]   r_gray_a;
    logic                          r_gsel_a;

    logic [nacm_pkg::PROD_W-1:0]   n_prod_r;
    logic [nacm_pkg::PROD_W-1:0]   n_prod_g;
    logic [nacm_pkg::PROD_W-1:0]   n_prod_b;
    logic                          r_vld_b;
    nacm_pkg::t_rgb                r_a_b;
    logic [nacm_pkg::PROD_W-1:0]   r_prod_r;
    logic [nacm_pkg::PROD_W-1:0]   r_prod_g;
    logic [nacm_pkg::PROD_W-1:0]   r_prod_b;
    logic [nacm_pkg::CHAN_W-1:0]   r_gray_b;
    logic                          r_gsel_b;

    // Stage A: clamp, gray value, segment and stop lookup.
    always_comb begin
        if (i_res.zero) begin
            w_v = '0;
        end else if (i_res.sat) begin
            w_v = nacm_pkg::ONE;
        end else begin
            w_v = {1'b0, i_res.quo};
        end
        w_gray_acc = {w_v, {nacm_pkg::CHAN_W{1'b0}}}
                   - {{nacm_pkg::CHAN_W{1'b0}}, w_v}
                   + {{nacm_pkg::CHAN_W{1'b0}}, nacm_pkg::HALF};
        w_seg_raw = w_v[nacm_pkg::FRAC_BITS:nacm_pkg::FRAC_BITS-2];
        w_seg     = w_seg_raw[2] ? 2'd3 : w_seg_raw[1:0];
        w_t_wide  = {w_v, 2'b00} - {1'b0, w_seg, {nacm_pkg::FRAC_BITS{1'b0}}};
        w_a       = nacm_pkg::stop_rgb({1'b0, w_seg});
        w_b       = nacm_pkg::stop_rgb({1'b0, w_seg} + 3'd1);
        n_delta.r = $signed({1'b0, w_b.r}) - $signed({1'b0, w_a.r});
        n_delta.g = $signed({1'b0, w_b.g}) - $signed({1'b0, w_a.g});
        n_delta.b = $signed({1'b0, w_b.b}) - $signed({1'b0, w_a.b});
    end

    // Stage B: one signed multiply per channel.
    always_comb begin
        n_prod_r = r_delta.r * $signed({1'b0, r_t});
        n_prod_g = r_delta.g * $signed({1'b0, r_t});
        n_prod_b = r_delta.b * $signed({1'b0, r_t});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_a    <= w_a;
            r_delta  <= n_delta;
            r_t      <= w_t_wide[nacm_pkg::V_W-1:0];
            r_gray_a <= w_gray_acc[nacm_pkg::FRAC_BITS+nacm_pkg::CHAN_W-1:nacm_pkg::FRAC_BITS];
            r_gsel_a <= i_gray;
            r_a_b    <= r_a_a;
            r_prod_r <= n_prod_r;
            r_prod_g <= n_prod_g;
            r_prod_b <= n_prod_b;
            r_gray_b <= r_gray_a;
            r_gsel_b <= r_gsel_a;
        end
    end

    always_comb begin
        if (r_gsel_b) begin
            o_rgb = '{r: r_gray_b, g: r_gray_b, b: r_gray_b};
        end else begin
            o_rgb.r = lerp_finish(r_a_b.r, r_prod_r);
            o_rgb.g = lerp_finish(r_a_b.g, r_prod_g);
            o_rgb.b = lerp_finish(r_a_b.b, r_prod_b);
        end
    end

    assign o_valid = r_vld_b;

endmodule

/* sv/normalize_and_colormap_pixel.sv */
// Path from input to o_out_valid: norm, FRAC_BITS divider, cmap and output registers.
// Throughput: one sample per cycle; the divider takes one quotient bit per pipeline stage,
// so its FRAC_BITS stages set the depth but not the rate.
// A stall on the output channel holds every stage; o_in_ready follows the output register.
// Reset (i_rst_n low at a clock edge) clears all valid bits and loads the bounds to 0.0 and
// 1.0 and selects the viridis map; payload registers are not reset.
// ----------------------------------------------------------------------------
// normalize_and_colormap_pixel: scalar sample to RGB pixel
// Normalizes a signed Q8.16 sample against the configured bounds, clamps it
// to [0,1] and maps it either to gray or through a five-stop colormap.
// ----------------------------------------------------------------------------
module normalize_and_colormap_pixel (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Sample channel.
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [nacm_pkg::SAMPLE_W-1:0]   i_sample,
    // Pixel channel.
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [nacm_pkg::CHAN_W-1:0]     o_red,
    output logic [nacm_pkg::CHAN_W-1:0]     o_green,
    output logic [nacm_pkg::CHAN_W-1:0]     o_blue,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nacm_pkg::PADDR_W-1:0]    paddr,
    input  logic [nacm_pkg::PDATA_W-1:0]    pwdata,
    output logic [nacm_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    // Configuration registers. The user must change them only while the pipeline is empty
    // and the block does not enforce this. The bounds are read directly, not carried.
    logic [nacm_pkg::SAMPLE_W-1:0]      r_lower_bound;
    logic [nacm_pkg::SAMPLE_W-1:0]      r_upper_bound;
    logic                               r_gray_select;
    logic                               w_cfg_write;
    logic [nacm_pkg::REG_IDX_W-1:0]     w_reg_idx;

    // Pipeline control: the whole pipe moves when the output register can
    // take a new value, that is when it is empty or being drained.
    logic                               w_adv;
    logic                               w_norm_valid;
    nacm_pkg::t_div_op                  w_div_op;
    logic                               w_div_valid;
    nacm_pkg::t_div_res                 w_div_res;
    logic                               w_cmap_valid;
    nacm_pkg::t_rgb                     w_cmap_rgb;
    logic                               r_out_valid;
    nacm_pkg::t_rgb                     r_out_rgb;

    assign pready      = 1'b1;
    assign w_reg_idx   = paddr[nacm_pkg::PADDR_W-1:2];
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_bound <= '0;
            r_upper_bound <= nacm_pkg::SAMPLE_W'(nacm_pkg::ONE);
            r_gray_select <= 1'b0;
        end else if (w_cfg_write) begin
            unique case (w_reg_idx)
                nacm_pkg::REG_LOWER: r_lower_bound <= pwdata[nacm_pkg::SAMPLE_W-1:0];
                nacm_pkg::REG_UPPER: r_upper_bound <= pwdata[nacm_pkg::SAMPLE_W-1:0];
                nacm_pkg::REG_GRAY:  r_gray_select <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read data is returned zero-extended; addresses past the map read zero.
    always_comb begin
        unique case (w_reg_idx)
            nacm_pkg::REG_LOWER:
                prdata = {{(nacm_pkg::PDATA_W-nacm_pkg::SAMPLE_W){1'b0}}, r_lower_bound};
            nacm_pkg::REG_UPPER:
                prdata = {{(nacm_pkg::PDATA_W-nacm_pkg::SAMPLE_W){1'b0}}, r_upper_bound};
            nacm_pkg::REG_GRAY:
                prdata = {{(nacm_pkg::PDATA_W-1){1'b0}}, r_gray_select};
            default:
                prdata = '0;
        endcase
    end

    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    // Offset, range and clamp flags.
    nacm_norm u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_valid  (i_in_valid),
        .i_sample (i_sample),
        .i_lower  (r_lower_bound),
        .i_upper  (r_upper_bound),
        .o_valid  (w_norm_valid),
        .o_op     (w_div_op)
    );

    // Fractional quotient, one bit per stage.
    nacm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_norm_valid),
        .i_op    (w_div_op),
        .o_valid (w_div_valid),
        .o_res   (w_div_res)
    );

    // Gray or colormap interpolation.
    nacm_cmap u_cmap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_div_valid),
        .i_res   (w_div_res),
        .i_gray  (r_gray_select),
        .o_valid (w_cmap_valid),
        .o_rgb   (w_cmap_rgb)
    );

    // Output register. It holds a finished pixel while the consumer stalls,
    // and the rounding add of the interpolation lands here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_cmap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_rgb <= w_cmap_rgb;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_red       = r_out_rgb.r;
    assign o_green     = r_out_rgb.g;
    assign o_blue      = r_out_rgb.b;

endmodule

/* sv/nacm_checker.sv */
// ----------------------------------------------------------------------------
// nacm_checker: port-level checks for the pixel pipeline
// Watches handshakes and the configuration port of the top level.
// ----------------------------------------------------------------------------
module nacm_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_ready,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  logic [nacm_pkg::CHAN_W-1:0]     o_red,
    input  logic [nacm_pkg::CHAN_W-1:0]     o_green,
    input  logic [nacm_pkg::CHAN_W-1:0]     o_blue,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pready
);

    // No pixel is offered in the cycle after a reset edge.
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("pixel valid after reset");

    // A pixel held for a stalled consumer keeps its value.
    a_stalled_pixel_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable({o_red, o_green, o_blue}))
        else $error("stalled pixel changed");

    // With the output register empty the pipeline must take a sample.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    // A stalled pixel freezes the pipeline, so no sample may enter.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("sample taken during output stall");

    // The configuration port never inserts wait states.
    a_no_wait_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable |-> pready)
        else $error("configuration access stalled");

endmodule

bind normalize_and_colormap_pixel nacm_checker u_nacm_checker (.*);

/* verif/tb_normalize_and_colormap_pixel.sv */
// ----------------------------------------------------------------------------
// tb_normalize_and_colormap_pixel: self-checking bench for the pixel colorizer
// Drives signed Q8.16 samples through the valid/ready sample channel under
// several bound and map settings written over the APB port. Every pixel is
// checked channel by channel against a fixed-point prediction made when its
// sample transaction is accepted. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_normalize_and_colormap_pixel;
    timeunit 1ns;
    timeprecision 1ps;

    localparam real    CLK_HALF       = 4.0;
    localparam int     RESET_CYCLES   = 9;
    // The pipeline is FRAC_BITS + 5 stages deep; leave some margin past that.
    localparam int     SETTLE_CYCLES  = nacm_pkg::FRAC_BITS + 5 + 8;
    localparam int     LONG_HOLD      = 300;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     RANDOM_PHASES  = 8;
    localparam int     PHASE_ITEMS    = 200;
    // Index 3 has no register behind it; writes there must change nothing.
    localparam logic [nacm_pkg::REG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam longint Q_MIN = -(longint'(1) << (nacm_pkg::SAMPLE_W - 1));
    localparam longint Q_MAX = (longint'(1) << (nacm_pkg::SAMPLE_W - 1)) - 1;
    localparam longint Q_ONE = longint'(1) << nacm_pkg::FRAC_BITS;

    // One expected pixel, with the sample that produced it for diagnostics.
    typedef struct {
        logic [nacm_pkg::SAMPLE_W-1:0] smp;
        nacm_pkg::t_rgb                px;
    } t_pixel_expect;

    // Block ports. Every input starts from a known value.
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    logic [nacm_pkg::SAMPLE_W-1:0] i_sample    = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [nacm_pkg::CHAN_W-1:0]   o_red;
    logic [nacm_pkg::CHAN_W-1:0]   o_green;
    logic [nacm_pkg::CHAN_W-1:0]   o_blue;
    logic                          psel        = 1'b0;
    logic                          penable     = 1'b0;
    logic                          pwrite      = 1'b0;
    logic [nacm_pkg::PADDR_W-1:0]  paddr       = '0;
    logic [nacm_pkg::PDATA_W-1:0]  pwdata      = '0;
    logic [nacm_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    // Colormap stops, darkest first, one row of red, green and blue per stop.
    int stop_lvl [5][3] = '{'{68, 1, 84}, '{59, 82, 139}, '{33, 145, 140},
                            '{94, 201, 98}, '{253, 231, 37}};

    // Shadow copy of the configuration, updated as each write completes.
    logic [nacm_pkg::SAMPLE_W-1:0] cfg_lower = '0;
    logic [nacm_pkg::SAMPLE_W-1:0] cfg_upper = nacm_pkg::SAMPLE_W'(Q_ONE);
    logic                          cfg_gray  = 1'b0;

    logic [nacm_pkg::SAMPLE_W-1:0] sample_q [$];   // samples waiting to be offered
    t_pixel_expect                 pixel_q  [$];   // pixels predicted, not yet seen

    logic sample_taken  = 1'b0;          // sample transaction at the last rising edge
    int   src_gap       = 0;
    int   sink_gap      = 0;
    int   src_idle_pct  = 0;
    int   sink_idle_pct = 0;
    int   hold_requests = 0;
    int   holds_served  = 0;
    int   stall_cycles  = 0;
    int   errors        = 0;

    normalize_and_colormap_pixel u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Saturate a wide value into the signed sample format.
    function automatic logic [nacm_pkg::SAMPLE_W-1:0] to_q(input longint x);
        if (x < Q_MIN)
            x = Q_MIN;
        else if (x > Q_MAX)
            x = Q_MAX;
        return x[nacm_pkg::SAMPLE_W-1:0];
    endfunction

    // Pixel predicted for one sample under the current shadow configuration.
    // The sample is normalized to v in Q1.FRAC_BITS, clamped to [0, 1.0]. Gray
    // mode rounds v*255; the colormap picks a segment from the top two bits of
    // 4*v and blends its two stops with the remaining fraction, rounding half up.
    function automatic nacm_pkg::t_rgb map_pixel(input logic [nacm_pkg::SAMPLE_W-1:0] smp);
        longint                      s;
        longint                      lo;
        longint                      hi;
        longint                      diff;
        longint                      span;
        longint                      v;
        longint                      seg;
        longint                      frac;
        longint                      acc;
        logic [nacm_pkg::CHAN_W-1:0] lvl [3];
        s    = $signed(smp);
        lo   = $signed(cfg_lower);
        hi   = $signed(cfg_upper);
        diff = s - lo;
        // Empty or inverted bounds fall back to a range of 1.0.
        span = (hi > lo) ? hi - lo : Q_ONE;
        if (diff <= 0)
            v = 0;
        else if (diff >= span)
            v = Q_ONE;
        else
            v = (diff <<< nacm_pkg::FRAC_BITS) / span;
        seg = v >>> (nacm_pkg::FRAC_BITS - 2);
        if (seg > 3)
            seg = 3;
        frac = (v <<< 2) - (seg <<< nacm_pkg::FRAC_BITS);
        for (int c = 0; c < 3; c++) begin
            if (cfg_gray)
                acc = v * 255 + (Q_ONE >>> 1);
            else
                acc = stop_lvl[seg][c] * Q_ONE
                      + (stop_lvl[seg + 1][c] - stop_lvl[seg][c]) * frac
                      + (Q_ONE >>> 1);
            if (acc < 0)
                acc = 0;
            lvl[c] = acc[nacm_pkg::FRAC_BITS +: nacm_pkg::CHAN_W];
        end
        return '{r: lvl[0], g: lvl[1], b: lvl[2]};
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 8;
            default: return 30;
        endcase
    endfunction

    task automatic check_chan(input string chan, input logic [nacm_pkg::SAMPLE_W-1:0] smp,
                              input logic [nacm_pkg::CHAN_W-1:0] want,
                              input logic [nacm_pkg::CHAN_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch for sample 0x%06h, expected %0d, actual %0d",
                     $time, chan, smp, want, got);
            errors++;
        end
    endtask

    // APB write: setup cycle, access cycle, then back to idle. The shadow copy
    // follows only for the mapped registers, and only the bits they hold.
    task automatic apb_write(input logic [nacm_pkg::REG_IDX_W-1:0] idx,
                             input logic [nacm_pkg::PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            nacm_pkg::REG_LOWER: cfg_lower = data[nacm_pkg::SAMPLE_W-1:0];
            nacm_pkg::REG_UPPER: cfg_upper = data[nacm_pkg::SAMPLE_W-1:0];
            nacm_pkg::REG_GRAY:  cfg_gray  = data[0];
            default:   ;
        endcase
    endtask

    // APB read of one register; only the bits the register holds are compared.
    task automatic apb_read_check(input logic [nacm_pkg::REG_IDX_W-1:0] idx);
        logic [nacm_pkg::PDATA_W-1:0] got;
        logic [nacm_pkg::PDATA_W-1:0] want;
        logic [nacm_pkg::PDATA_W-1:0] mask;
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            nacm_pkg::REG_LOWER: begin
                mask = {{(nacm_pkg::PDATA_W - nacm_pkg::SAMPLE_W){1'b0}},
                        {nacm_pkg::SAMPLE_W{1'b1}}};
                want = nacm_pkg::PDATA_W'(cfg_lower);
            end
            nacm_pkg::REG_UPPER: begin
                mask = {{(nacm_pkg::PDATA_W - nacm_pkg::SAMPLE_W){1'b0}},
                        {nacm_pkg::SAMPLE_W{1'b1}}};
                want = nacm_pkg::PDATA_W'(cfg_upper);
            end
            default: begin
                mask = nacm_pkg::PDATA_W'(1);
                want = nacm_pkg::PDATA_W'(cfg_gray);
            end
        endcase
        if ((got & mask) !== want) begin
            $display("%0t: readback of register %0d, expected 0x%08h, actual 0x%08h",
                     $time, idx, want, got & mask);
            errors++;
        end
    endtask

    task automatic check_all_regs();
        apb_read_check(nacm_pkg::REG_LOWER);
        apb_read_check(nacm_pkg::REG_UPPER);
        apb_read_check(nacm_pkg::REG_GRAY);
    endtask

    // Writes all three registers with random junk above their widths, pokes
    // the unmapped index, and reads everything back.
    task automatic apply_settings(input logic [nacm_pkg::SAMPLE_W-1:0] lo,
                                  input logic [nacm_pkg::SAMPLE_W-1:0] hi,
                                  input logic gray);
        logic [nacm_pkg::PDATA_W-1:0] junk;
        junk = $urandom;
        apb_write(nacm_pkg::REG_LOWER, {junk[nacm_pkg::PDATA_W-1:nacm_pkg::SAMPLE_W], lo});
        junk = $urandom;
        apb_write(nacm_pkg::REG_UPPER, {junk[nacm_pkg::PDATA_W-1:nacm_pkg::SAMPLE_W], hi});
        junk = $urandom;
        apb_write(nacm_pkg::REG_GRAY, {junk[nacm_pkg::PDATA_W-1:1], gray});
        apb_write(REG_SPARE, $urandom);
        check_all_regs();
    endtask

    // Mostly proper bounds with spans spread over every scale, plus empty,
    // inverted and fully random pairs.
    task automatic random_settings();
        logic [nacm_pkg::SAMPLE_W-1:0] raw_lo;
        logic [nacm_pkg::SAMPLE_W-1:0] raw_hi;
        logic [nacm_pkg::SAMPLE_W-1:0] swap;
        longint                        lo;
        longint                        span;
        int                            kind;
        raw_lo = $urandom;
        raw_hi = $urandom;
        kind   = $urandom_range(0, 9);
        if (kind < 7) begin
            lo   = $signed(raw_lo);
            span = 1 + (longint'($urandom)
                        & ((longint'(1) << $urandom_range(0, nacm_pkg::SAMPLE_W - 1)) - 1));
            if (lo + span > Q_MAX)
                lo = Q_MAX - span;
            raw_lo = to_q(lo);
            raw_hi = to_q(lo + span);
        end else if (kind == 7) begin
            raw_hi = raw_lo;
        end else if (kind == 8 && $signed(raw_hi) > $signed(raw_lo)) begin
            swap   = raw_hi;
            raw_hi = raw_lo;
            raw_lo = swap;
        end
        apply_settings(raw_lo, raw_hi, 1'($urandom_range(0, 1)));
    endtask

    // Samples mostly fall across the active range with a margin on both sides,
    // some hug the bounds, and some are fully random 24-bit words.
    task automatic push_random_samples(input int n);
        logic [nacm_pkg::SAMPLE_W-1:0] raw;
        longint                        lo;
        longint                        hi;
        longint                        span;
        longint                        s;
        int                            pick;
        lo   = $signed(cfg_lower);
        hi   = $signed(cfg_upper);
        span = (hi > lo) ? hi - lo : Q_ONE;
        repeat (n) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                raw = $urandom;
                s   = $signed(raw);
            end else if (pick == 1) begin
                s = lo + int'($urandom_range(0, 4)) - 2;
            end else if (pick == 2) begin
                s = hi + int'($urandom_range(0, 4)) - 2;
            end else begin
                s = lo - span / 8 + longint'($urandom) % (span + span / 4 + 1);
            end
            sample_q.push_back(to_q(s));
        end
    endtask

    task automatic probe(input longint x);
        sample_q.push_back(to_q(x));
    endtask

    // Waits until every queued sample has been taken and every predicted pixel
    // has come out, then lets the pipeline settle.
    task automatic wait_all_results();
        while (sample_q.size() != 0 || i_in_valid || pixel_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Sample driver. A new sample goes out only once the previous transaction
    // has completed; after each launch a random idle burst may be scheduled.
    always @(negedge i_clk) begin
        if (!i_in_valid || sample_taken) begin
            if (src_gap != 0) begin
                src_gap--;
                i_in_valid <= 1'b0;
            end else if (sample_q.size() != 0) begin
                i_in_valid <= 1'b1;
                i_sample   <= sample_q.pop_front();
                if ($urandom_range(0, 99) < src_idle_pct)
                    src_gap = $urandom_range(1, 15);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Pixel receiver. A long hold, when requested, is counted out here and
    // overrides any random stall in progress.
    always @(negedge i_clk) begin
        if (holds_served != hold_requests) begin
            holds_served++;
            sink_gap = LONG_HOLD;
        end
        if (sink_gap != 0) begin
            sink_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 99) < sink_idle_pct)
                sink_gap = $urandom_range(1, 15);
        end
    end

    // Monitor. Accepted samples are turned into predictions at once; accepted
    // pixels are compared with the oldest prediction. The watchdog ends the run
    // when no transaction of any kind has happened for too long.
    always @(posedge i_clk) begin
        t_pixel_expect want;
        sample_taken = i_in_valid && o_in_ready;
        if (sample_taken)
            pixel_q.push_back('{smp: i_sample, px: map_pixel(i_sample)});
        if (o_out_valid && i_out_ready) begin
            if (pixel_q.size() == 0) begin
                $display("%0t: pixel with no sample pending, actual %0d %0d %0d",
                         $time, o_red, o_green, o_blue);
                errors++;
            end else begin
                want = pixel_q.pop_front();
                check_chan("red", want.smp, want.px.r, o_red);
                check_chan("green", want.smp, want.px.g, o_green);
                check_chan("blue", want.smp, want.px.b, o_blue);
            end
        end
        if (sample_taken || (o_out_valid && i_out_ready) || (psel && penable)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, no transaction for %0d cycles", $time, stall_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Stimulus sequence: reset, directed corner cases under fixed settings,
    // then random phases, each under new random settings.
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: bounds 0.0 and 1.0, colormap mode.
        check_all_regs();
        src_idle_pct  = pick_idle_pct();
        sink_idle_pct = pick_idle_pct();
        probe(Q_MIN);
        probe(Q_MAX);
        probe(0);
        probe(1);
        probe(Q_ONE / 4 - 1);
        probe(Q_ONE / 4);
        probe(Q_ONE / 2);
        probe(3 * Q_ONE / 4);
        probe(Q_ONE - 1);
        probe(Q_ONE);

        // Gray mode over the same bounds, including the rounding midpoint.
        wait_all_results();
        apply_settings('0, to_q(Q_ONE), 1'b1);
        probe(-5);
        probe(Q_ONE / 2 - 1);
        probe(Q_ONE / 2);
        probe(Q_ONE - 1);
        probe(Q_ONE);

        // Empty bounds: the range falls back to 1.0 above the lower bound.
        wait_all_results();
        apply_settings(to_q(5 * Q_ONE), to_q(5 * Q_ONE), 1'b0);
        probe(5 * Q_ONE - 1);
        probe(5 * Q_ONE + 1);
        probe(5 * Q_ONE + Q_ONE / 2);
        probe(6 * Q_ONE);

        // Inverted bounds in gray mode.
        wait_all_results();
        apply_settings(to_q(Q_ONE), to_q(-Q_ONE), 1'b1);
        probe(Q_ONE);
        probe(Q_ONE + Q_ONE / 2);
        probe(2 * Q_ONE);
        probe(Q_MIN);

        // Widest possible range.
        wait_all_results();
        apply_settings(to_q(Q_MIN), to_q(Q_MAX), 1'b0);
        probe(Q_MIN);
        probe(0);
        probe(Q_MAX - 1);
        probe(Q_MAX);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_all_results();
            random_settings();
            if (ph == RANDOM_PHASES - 1) begin
                // Final stretch runs at full rate on both sides.
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct  = pick_idle_pct();
                sink_idle_pct = pick_idle_pct();
            end
            push_random_samples(PHASE_ITEMS / 2);
            if (ph == 2)
                hold_requests++;      // receiver backs off while samples keep coming
            else if (ph == 4)
                wait_all_results();   // sender pauses until the pipe is empty
            push_random_samples(PHASE_ITEMS / 2);
        end
        wait_all_results();

        if (errors == 0 && pixel_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
sv/nacm_pkg.sv
sv/nacm_norm.sv
sv/nacm_div.sv
sv/nacm_cmap.sv
sv/normalize_and_colormap_pixel.sv
sv/nacm_checker.sv
verif/tb_normalize_and_colormap_pixel.sv
